[hw/rtl/atwa_pkg.sv]
// Package for the apparent-to-true wind angle converter.
// Holds widths, CORDIC arctangent table and shared constants. No dependencies.
`timescale 1ns / 1ps
package atwa_pkg;
    localparam int ANGLE_BITS   = 16;
    localparam int SPEED_BITS   = 16;
    localparam int FRAC_EXTRA   = 30 - SPEED_BITS;
    localparam int CORDIC_STEPS = 30;
    localparam int CW           = 34;   // rotation CORDIC width (Q30 plus sign/growth)
    localparam int VW           = 50;   // vectoring CORDIC width
    localparam int ZW           = 34;   // angle accumulator width
    localparam int SQW          = 64;   // radicand width
    localparam int RW           = 32;   // root width
    localparam logic signed [CW-1:0] CORDIC_START = CW'(652032874);
    localparam logic signed [ZW-1:0] QUARTER_TURN = ZW'(64'd1 << 30);
    localparam logic signed [ZW-1:0] HALF_TURN    = ZW'(64'd1 << 31);

    function automatic logic signed [ZW-1:0] atan_turn(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0: v = 32'd536870912;  5'd1: v = 32'd316933406;
            5'd2: v = 32'd167458907;  5'd3: v = 32'd85004756;
            5'd4: v = 32'd42667331;   5'd5: v = 32'd21354465;
            5'd6: v = 32'd10679838;   5'd7: v = 32'd5340245;
            5'd8: v = 32'd2670163;    5'd9: v = 32'd1335087;
            5'd10: v = 32'd667544;    5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;    5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;     5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;     5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;      5'd19: v = 32'd1304;
            5'd20: v = 32'd652;       5'd21: v = 32'd326;
            5'd22: v = 32'd163;       5'd23: v = 32'd81;
            5'd24: v = 32'd41;        5'd25: v = 32'd20;
            5'd26: v = 32'd10;        5'd27: v = 32'd5;
            5'd28: v = 32'd3;         5'd29: v = 32'd1;
            default: v = 32'd0;
        endcase
        return ZW'(v);
    endfunction
endpackage

[hw/rtl/apparent_to_true_wind_angle.sv]
// Apparent-to-true wind angle converter, top level.
// Depends on atwa_pkg.
//
//  channel | ports                                              | dir
//  s_      | s_valid s_ready s_apparent_angle/speed s_boat_speed | in
//  m_      | m_valid m_ready m_true_angle m_true_speed m_no_true_wind | out
//
// One word per cycle in and out when m_ is not stalled. Stages: 1 fold stage,
// 30 rotation CORDIC stages, 1 mirror, 1 multiply stage (partial products),
// 1 round, 1 square, 32 square-root stages, 1 decision, 30 vectoring stages,
// 1 final. The longest per-stage path is the square stage (two 32x32 squares
// and their sum). The whole pipe advances together; a stall at m_ freezes
// every stage (global enable), so nothing is lost or repeated. Reset clears
// the valid bits only.
`timescale 1ns / 1ps
module apparent_to_true_wind_angle (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [atwa_pkg::ANGLE_BITS-1:0]  s_apparent_angle,
    input  logic [atwa_pkg::SPEED_BITS-1:0]  s_apparent_speed,
    input  logic [atwa_pkg::SPEED_BITS-1:0]  s_boat_speed,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [atwa_pkg::ANGLE_BITS-1:0]  m_true_angle,
    output logic [atwa_pkg::SPEED_BITS:0]    m_true_speed,
    output logic                             m_no_true_wind
);
    import atwa_pkg::*;

    localparam int NS = CORDIC_STEPS;
    localparam int NQ = RW;   // sqrt steps

    // pipe advances when output slot is free or being drained
    logic adv;
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // ---------------- stage F: fold to 0..pi, phase to quarter turn
    logic                  f_v_reg;
    logic [ANGLE_BITS-1:0] f_theta_reg;
    logic [SPEED_BITS-1:0] f_a_reg, f_g_reg;
    logic signed [ZW-1:0]  f_z_reg;
    logic                  f_mir_reg;

    logic [ANGLE_BITS-1:0] th_next;
    logic signed [ZW-1:0]  z0, z_next;
    always_comb begin
        th_next = (s_apparent_angle > ANGLE_BITS'(1 << (ANGLE_BITS-1)))
                ? ANGLE_BITS'(-s_apparent_angle) : s_apparent_angle;
        z0 = ZW'({th_next, {(32-ANGLE_BITS){1'b0}}});
        z_next = (z0 > QUARTER_TURN) ? HALF_TURN - z0 : z0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_v_reg <= 1'b0;
        end else if (adv) begin
            f_v_reg <= s_valid;
        end
        if (adv) begin
            f_theta_reg <= th_next;
            f_a_reg     <= s_apparent_speed;
            f_g_reg     <= s_boat_speed;
            f_z_reg     <= z_next;
            f_mir_reg   <= (z0 > QUARTER_TURN);
        end
    end

    // ---------------- rotation CORDIC, one step per stage
    logic                  r_v_reg  [NS+1];
    logic signed [CW-1:0]  r_x_reg  [NS+1];
    logic signed [CW-1:0]  r_y_reg  [NS+1];
    logic signed [ZW-1:0]  r_z_reg  [NS+1];
    logic [ANGLE_BITS-1:0] r_th_reg [NS+1];
    logic [SPEED_BITS-1:0] r_a_reg  [NS+1];
    logic [SPEED_BITS-1:0] r_g_reg  [NS+1];
    logic                  r_m_reg  [NS+1];

    always_comb begin
        r_v_reg[0] = f_v_reg;   r_x_reg[0] = CORDIC_START;
        r_y_reg[0] = '0;        r_z_reg[0] = f_z_reg;
        r_th_reg[0] = f_theta_reg; r_a_reg[0] = f_a_reg;
        r_g_reg[0] = f_g_reg;   r_m_reg[0] = f_mir_reg;
    end

    for (genvar i = 0; i < NS; i++) begin : g_rot
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                r_v_reg[i+1] <= 1'b0;
            end else if (adv) begin
                r_v_reg[i+1] <= r_v_reg[i];
            end
            if (adv) begin
                if (!r_z_reg[i][ZW-1]) begin
                    r_x_reg[i+1] <= r_x_reg[i] - (r_y_reg[i] >>> i);
                    r_y_reg[i+1] <= r_y_reg[i] + (r_x_reg[i] >>> i);
                    r_z_reg[i+1] <= r_z_reg[i] - atan_turn(5'(i));
                end else begin
                    r_x_reg[i+1] <= r_x_reg[i] + (r_y_reg[i] >>> i);
                    r_y_reg[i+1] <= r_y_reg[i] - (r_x_reg[i] >>> i);
                    r_z_reg[i+1] <= r_z_reg[i] + atan_turn(5'(i));
                end
                r_th_reg[i+1] <= r_th_reg[i];
                r_a_reg[i+1]  <= r_a_reg[i];
                r_g_reg[i+1]  <= r_g_reg[i];
                r_m_reg[i+1]  <= r_m_reg[i];
            end
        end
    end

    // ---------------- mirror cosine
    logic                  c_v_reg;
    logic signed [CW-1:0]  c_x_reg, c_y_reg;
    logic [ANGLE_BITS-1:0] c_th_reg;
    logic [SPEED_BITS-1:0] c_a_reg, c_g_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_v_reg <= 1'b0;
        end else if (adv) begin
            c_v_reg <= r_v_reg[NS];
        end
        if (adv) begin
            c_x_reg  <= r_m_reg[NS] ? -r_x_reg[NS] : r_x_reg[NS];
            c_y_reg  <= r_y_reg[NS];
            c_th_reg <= r_th_reg[NS];
            c_a_reg  <= r_a_reg[NS];
            c_g_reg  <= r_g_reg[NS];
        end
    end

    // ---------------- multiply: split cos/sin into low 17 and high parts
    localparam int PW = CW + SPEED_BITS + 2;
    localparam int XW = 64;
    logic                  p_v_reg;
    logic signed [PW-1:0]  p_xl_reg, p_xh_reg, p_yl_reg, p_yh_reg;
    logic [SPEED_BITS-1:0] p_g_reg;
    logic [ANGLE_BITS-1:0] p_th_reg;
    logic signed [SPEED_BITS:0] a_s;
    assign a_s = {1'b0, c_a_reg};
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_v_reg <= 1'b0;
        end else if (adv) begin
            p_v_reg <= c_v_reg;
        end
        if (adv) begin
            p_xl_reg <= PW'($signed({1'b0, c_x_reg[16:0]}) * a_s);
            p_xh_reg <= PW'($signed(c_x_reg[CW-1:17]) * a_s);
            p_yl_reg <= PW'($signed({1'b0, c_y_reg[16:0]}) * a_s);
            p_yh_reg <= PW'($signed(c_y_reg[CW-1:17]) * a_s);
            p_g_reg  <= c_g_reg;
            p_th_reg <= c_th_reg;
        end
    end

    // ---------------- sum partial products, subtract boat speed, round, absolute values
    logic signed [XW-1:0] x_full, y_full, xr_w, yr_w;
    always_comb begin
        x_full = (XW'(p_xh_reg) <<< 17) + XW'(p_xl_reg)
               - (XW'({1'b0, p_g_reg}) <<< 30);
        y_full = (XW'(p_yh_reg) <<< 17) + XW'(p_yl_reg);
        xr_w = (x_full + (XW'(1) <<< (SPEED_BITS-1))) >>> SPEED_BITS;
        yr_w = (y_full + (XW'(1) <<< (SPEED_BITS-1))) >>> SPEED_BITS;
    end

    logic                  q_v_reg;
    logic signed [RW:0]    q_x_reg;
    logic [RW-1:0]         q_y_reg, q_ax_reg;
    logic [ANGLE_BITS-1:0] q_th_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_v_reg <= 1'b0;
        end else if (adv) begin
            q_v_reg <= p_v_reg;
        end
        if (adv) begin
            q_x_reg  <= (RW+1)'(xr_w);
            q_ax_reg <= RW'(xr_w[XW-1] ? -xr_w : xr_w);
            q_y_reg  <= RW'(yr_w[XW-1] ? -yr_w : yr_w);
            q_th_reg <= p_th_reg;
        end
    end

    // ---------------- square and sum
    logic                  s2_v_reg;
    logic [SQW-1:0]        s2_sum_reg;
    logic signed [RW:0]    s2_x_reg;
    logic [RW-1:0]         s2_y_reg;
    logic [ANGLE_BITS-1:0] s2_th_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_v_reg <= 1'b0;
        end else if (adv) begin
            s2_v_reg <= q_v_reg;
        end
        if (adv) begin
            s2_sum_reg <= SQW'(q_ax_reg) * SQW'(q_ax_reg)
                        + SQW'(q_y_reg) * SQW'(q_y_reg);
            s2_x_reg  <= q_x_reg;
            s2_y_reg  <= q_y_reg;
            s2_th_reg <= q_th_reg;
        end
    end

    // ---------------- restoring square root, one result bit per stage
    logic                  t_v_reg  [NQ+1];
    logic [SQW-1:0]        t_n_reg  [NQ+1];
    logic [RW-1:0]         t_r_reg  [NQ+1];
    logic signed [RW:0]    t_x_reg  [NQ+1];
    logic [RW-1:0]         t_y_reg  [NQ+1];
    logic [ANGLE_BITS-1:0] t_th_reg [NQ+1];
    always_comb begin
        t_v_reg[0] = s2_v_reg;  t_n_reg[0] = s2_sum_reg; t_r_reg[0] = '0;
        t_x_reg[0] = s2_x_reg;  t_y_reg[0] = s2_y_reg;   t_th_reg[0] = s2_th_reg;
    end

    for (genvar k = 0; k < NQ; k++) begin : g_sqrt
        localparam int B = NQ - 1 - k;
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                t_v_reg[k+1] <= 1'b0;
            end else if (adv) begin
                t_v_reg[k+1] <= t_v_reg[k];
            end
            if (adv) begin
                // r2 = (r << (B+1)) + (1 << 2B); compare with remainder
                if ((SQW+2)'(t_n_reg[k]) >= ((SQW+2)'(t_r_reg[k]) << (B+1))
                                            + ((SQW+2)'(1) << (2*B))) begin
                    t_n_reg[k+1] <= t_n_reg[k] - SQW'(((SQW+2)'(t_r_reg[k]) << (B+1))
                                                + ((SQW+2)'(1) << (2*B)));
                    t_r_reg[k+1] <= t_r_reg[k] | (RW'(1) << B);
                end else begin
                    t_n_reg[k+1] <= t_n_reg[k];
                    t_r_reg[k+1] <= t_r_reg[k];
                end
                t_x_reg[k+1]  <= t_x_reg[k];
                t_y_reg[k+1]  <= t_y_reg[k];
                t_th_reg[k+1] <= t_th_reg[k];
            end
        end
    end

    // ---------------- round speed, pick vectoring start
    logic [RW-FRAC_EXTRA:0] ts_w;
    assign ts_w = (RW-FRAC_EXTRA+1)'((33'(t_r_reg[NQ]) + 33'(1 << (FRAC_EXTRA-1)))
                  >> FRAC_EXTRA);

    logic                  v_v_reg  [NS+1];
    logic signed [VW-1:0]  v_x_reg  [NS+1];
    logic signed [VW-1:0]  v_y_reg  [NS+1];
    logic signed [ZW-1:0]  v_z_reg  [NS+1];
    logic                  v_nt_reg [NS+1];
    logic [SPEED_BITS:0]   v_ts_reg [NS+1];
    logic [ANGLE_BITS-1:0] v_th_reg [NS+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_v_reg[0] <= 1'b0;
        end else if (adv) begin
            v_v_reg[0] <= t_v_reg[NQ];
        end
        if (adv) begin
            if (t_x_reg[NQ][RW]) begin
                v_x_reg[0] <= VW'(t_y_reg[NQ]);
                v_y_reg[0] <= -VW'(t_x_reg[NQ]);
                v_z_reg[0] <= QUARTER_TURN;
            end else begin
                v_x_reg[0] <= VW'(t_x_reg[NQ]);
                v_y_reg[0] <= VW'(t_y_reg[NQ]);
                v_z_reg[0] <= '0;
            end
            v_nt_reg[0] <= (ts_w == '0);
            v_ts_reg[0] <= (SPEED_BITS+1)'(ts_w);
            v_th_reg[0] <= t_th_reg[NQ];
        end
    end

    // ---------------- vectoring CORDIC
    for (genvar i = 0; i < NS; i++) begin : g_vec
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_v_reg[i+1] <= 1'b0;
            end else if (adv) begin
                v_v_reg[i+1] <= v_v_reg[i];
            end
            if (adv) begin
                if (!v_y_reg[i][VW-1]) begin
                    v_x_reg[i+1] <= v_x_reg[i] + (v_y_reg[i] >>> i);
                    v_y_reg[i+1] <= v_y_reg[i] - (v_x_reg[i] >>> i);
                    v_z_reg[i+1] <= v_z_reg[i] + atan_turn(5'(i));
                end else begin
                    v_x_reg[i+1] <= v_x_reg[i] - (v_y_reg[i] >>> i);
                    v_y_reg[i+1] <= v_y_reg[i] + (v_x_reg[i] >>> i);
                    v_z_reg[i+1] <= v_z_reg[i] - atan_turn(5'(i));
                end
                v_nt_reg[i+1] <= v_nt_reg[i];
                v_ts_reg[i+1] <= v_ts_reg[i];
                v_th_reg[i+1] <= v_th_reg[i];
            end
        end
    end

    // ---------------- clamp, round angle, output register
    logic signed [ZW-1:0] vz_c;
    logic [ZW-1:0]        ang_w;
    logic [ANGLE_BITS-1:0] ang_q;
    always_comb begin
        vz_c = v_z_reg[NS];
        if (vz_c < 0) vz_c = '0;
        if (vz_c > HALF_TURN) vz_c = HALF_TURN;
        ang_w = (ZW'(vz_c) + (ZW'(1) << (31 - ANGLE_BITS))) >> (32 - ANGLE_BITS);
        ang_q = (ang_w > ZW'(1 << (ANGLE_BITS-1))) ? ANGLE_BITS'(1 << (ANGLE_BITS-1))
                                                   : ANGLE_BITS'(ang_w);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (adv) begin
            m_valid <= v_v_reg[NS];
        end
        if (adv) begin
            m_no_true_wind <= v_nt_reg[NS];
            m_true_speed   <= v_ts_reg[NS];
            m_true_angle   <= v_nt_reg[NS] ? v_th_reg[NS] : ang_q;
        end
    end
endmodule
